[src/pmoc_pkg.sv]
`default_nettype none
package pmoc_pkg;
  localparam int NUM_CPUS_DEF = 4;
  localparam int MAX_CAPACITY_DEF = 64;
  localparam int POOL_MAGAZINES_DEF = 16;
  localparam logic [6:0] CAPACITY_RESET = 7'd64;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE = 1'b1;

  localparam logic [1:0] SRC_LOADED = 2'd0;
  localparam logic [1:0] SRC_PREVIOUS = 2'd1;
  localparam logic [1:0] SRC_DEPOT = 2'd2;
  localparam logic [1:0] SRC_BACKING = 2'd3;

  typedef struct packed {
    logic        operation;
    logic [5:0]  cpu;
    logic [31:0] handle;
  } in_item_t;

  typedef struct packed {
    logic        served;
    logic [31:0] handle_res;
    logic [1:0]  source;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_READ,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic decide;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_read;
  } ctrl_sts_t;
endpackage
`default_nettype wire

[src/pmoc_ram.sv]
`default_nettype none
module pmoc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[src/pmoc_ctrl.sv]
`default_nettype none
module pmoc_ctrl import pmoc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire ctrl_sts_t sts,
  output ctrl_cmd_t      cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = sts.need_read ? ST_READ : ST_OUT;
      ST_READ:   state_nxt = ST_OUT;
      ST_OUT:    if (!out_stall) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != ST_IDLE);
    out_valid = (state_r == ST_OUT);
    cmd.capture = (state_r == ST_IDLE) && in_valid;
    cmd.decide = (state_r == ST_DECIDE);
    cmd.finish = (state_r == ST_READ);
  end
endmodule
`default_nettype wire

[src/pmoc_dp.sv]
`default_nettype none
module pmoc_dp import pmoc_pkg::*; #(
  parameter int NUM_CPUS = NUM_CPUS_DEF,
  parameter int MAX_CAPACITY = MAX_CAPACITY_DEF,
  parameter int POOL_MAGAZINES = POOL_MAGAZINES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [6:0] cfg_wdata,
  input  wire in_item_t   in_item,
  input  wire ctrl_cmd_t  cmd,
  output ctrl_sts_t       sts,
  output out_item_t       out_item
);
  localparam int MW = (POOL_MAGAZINES > 1) ? $clog2(POOL_MAGAZINES) : 1;
  localparam int SW = $clog2(MAX_CAPACITY) > 0 ? $clog2(MAX_CAPACITY) : 1;
  localparam int FW = $clog2(MAX_CAPACITY + 1);
  localparam int DW = $clog2(POOL_MAGAZINES + 1);
  localparam int CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int AW = $clog2(POOL_MAGAZINES * MAX_CAPACITY);
  localparam int HD = POOL_MAGAZINES * MAX_CAPACITY;

  logic [6:0]    cap_r;
  logic [FW-1:0] fill_r [POOL_MAGAZINES];
  logic [MW-1:0] lm_r [NUM_CPUS];
  logic [MW-1:0] pm_r [NUM_CPUS];
  logic          lv_r [NUM_CPUS];
  logic          pv_r [NUM_CPUS];
  logic [MW-1:0] full_stk_r [POOL_MAGAZINES];
  logic [MW-1:0] empty_stk_r [POOL_MAGAZINES];
  logic [DW-1:0] full_dep_r, empty_dep_r, fresh_r;
  in_item_t      item_r;
  logic          served_r;
  logic [1:0]    src_r;
  logic [31:0]   res_r;
  logic          use_ram_r;

  logic [CW-1:0] cpu;
  logic [MW-1:0] lm, pm, fm, nm;
  logic          lv, pv;
  logic [FW-1:0] fl, fp, cap;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_rdata;

  always_comb begin
    if (cap_r == 7'd0) cap = FW'(1);
    else if ({25'd0, cap_r} > 32'(MAX_CAPACITY)) cap = FW'(MAX_CAPACITY);
    else cap = FW'(cap_r);
    if ({26'd0, item_r.cpu} >= 32'(NUM_CPUS)) cpu = '0;
    else cpu = CW'(item_r.cpu);
    lm = lm_r[cpu];
    pm = pm_r[cpu];
    lv = lv_r[cpu];
    pv = pv_r[cpu];
    fl = fill_r[lm];
    fp = fill_r[pm];
    fm = full_stk_r[MW'(full_dep_r - DW'(1))];
    nm = (empty_dep_r != '0) ? empty_stk_r[MW'(empty_dep_r - DW'(1))] : MW'(fresh_r);
  end

  // Decide phase: all bookkeeping plus the slot write for a free, or the
  // slot read address for an allocate.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAPACITY_RESET;
      full_dep_r <= '0;
      empty_dep_r <= '0;
      fresh_r <= DW'((2 * NUM_CPUS > POOL_MAGAZINES) ? POOL_MAGAZINES : 2 * NUM_CPUS);
      for (int i = 0; i < POOL_MAGAZINES; i++) fill_r[i] <= '0;
      for (int c = 0; c < NUM_CPUS; c++) begin
        lm_r[c] <= MW'(2 * c);
        pm_r[c] <= MW'(2 * c + 1);
        lv_r[c] <= (2 * c) < POOL_MAGAZINES;
        pv_r[c] <= (2 * c + 1) < POOL_MAGAZINES;
      end
    end else begin
      if (cfg_we) cap_r <= cfg_wdata;
      if (cmd.decide) begin
        if (item_r.operation == OP_ALLOC) begin
          if (lv && fl != '0) begin
            fill_r[lm] <= fl - FW'(1);
          end else if (pv && fp != '0) begin
            lm_r[cpu] <= pm; lv_r[cpu] <= 1'b1;
            pm_r[cpu] <= lm; pv_r[cpu] <= lv;
            fill_r[pm] <= fp - FW'(1);
          end else if (full_dep_r != '0) begin
            full_dep_r <= full_dep_r - DW'(1);
            if (lv && fl == '0 && empty_dep_r < DW'(POOL_MAGAZINES)) begin
              empty_stk_r[MW'(empty_dep_r)] <= lm;
              empty_dep_r <= empty_dep_r + DW'(1);
            end
            lm_r[cpu] <= fm; lv_r[cpu] <= 1'b1;
            if (fill_r[fm] != '0 && fill_r[fm] <= FW'(MAX_CAPACITY))
              fill_r[fm] <= fill_r[fm] - FW'(1);
          end
        end else begin
          if (lv && fl < cap) begin
            if (fl < FW'(MAX_CAPACITY)) fill_r[lm] <= fl + FW'(1);
          end else if (pv && fp < cap) begin
            lm_r[cpu] <= pm; lv_r[cpu] <= 1'b1;
            pm_r[cpu] <= lm; pv_r[cpu] <= lv;
            if (fp < FW'(MAX_CAPACITY)) fill_r[pm] <= fp + FW'(1);
          end else if (lv) begin
            if (full_dep_r < DW'(POOL_MAGAZINES)) begin
              full_stk_r[MW'(full_dep_r)] <= lm;
              full_dep_r <= full_dep_r + DW'(1);
            end
            if (empty_dep_r != '0) begin
              empty_dep_r <= empty_dep_r - DW'(1);
              lm_r[cpu] <= nm; lv_r[cpu] <= 1'b1;
              if (fill_r[nm] < FW'(MAX_CAPACITY)) fill_r[nm] <= fill_r[nm] + FW'(1);
            end else if (fresh_r < DW'(POOL_MAGAZINES)) begin
              fresh_r <= fresh_r + DW'(1);
              lm_r[cpu] <= nm; lv_r[cpu] <= 1'b1;
              fill_r[nm] <= FW'(1);
            end else begin
              lv_r[cpu] <= 1'b0;
            end
          end
        end
      end
    end
  end

  logic          d_served;
  logic [1:0]    d_src;
  logic [MW-1:0] d_mag;
  logic [FW-1:0] d_slot;
  logic          d_valid_slot;

  always_comb begin
    d_served = 1'b0; d_src = SRC_BACKING; d_mag = lm; d_slot = fl; d_valid_slot = 1'b0;
    if (item_r.operation == OP_ALLOC) begin
      if (lv && fl != '0) begin
        d_served = 1'b1; d_src = SRC_LOADED; d_mag = lm; d_slot = fl - FW'(1);
        d_valid_slot = 1'b1;
      end else if (pv && fp != '0) begin
        d_served = 1'b1; d_src = SRC_PREVIOUS; d_mag = pm; d_slot = fp - FW'(1);
        d_valid_slot = 1'b1;
      end else if (full_dep_r != '0) begin
        d_served = 1'b1; d_src = SRC_DEPOT; d_mag = fm; d_slot = fill_r[fm] - FW'(1);
        d_valid_slot = fill_r[fm] != '0 && fill_r[fm] <= FW'(MAX_CAPACITY);
      end
    end else begin
      if (lv && fl < cap) begin
        d_served = 1'b1; d_src = SRC_LOADED; d_mag = lm; d_slot = fl;
        d_valid_slot = fl < FW'(MAX_CAPACITY);
      end else if (pv && fp < cap) begin
        d_served = 1'b1; d_src = SRC_PREVIOUS; d_mag = pm; d_slot = fp;
        d_valid_slot = fp < FW'(MAX_CAPACITY);
      end else if (lv && (empty_dep_r != '0 || fresh_r < DW'(POOL_MAGAZINES))) begin
        d_served = 1'b1; d_src = SRC_DEPOT; d_mag = nm;
        d_slot = (empty_dep_r != '0) ? fill_r[nm] : '0;
        d_valid_slot = d_slot < FW'(MAX_CAPACITY);
      end
    end
  end

  logic [AW-1:0] d_addr;
  assign d_addr = AW'(d_mag) * AW'(MAX_CAPACITY) + AW'(d_slot[SW-1:0]);
  assign ram_we = cmd.decide && item_r.operation == OP_FREE && d_served && d_valid_slot;
  assign ram_waddr = d_addr;
  assign ram_raddr = d_addr;
  assign sts.need_read = item_r.operation == OP_ALLOC && d_served;

  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_item;
    if (cmd.decide) begin
      served_r <= d_served;
      src_r <= d_src;
      use_ram_r <= item_r.operation == OP_ALLOC && d_served && d_valid_slot;
      res_r <= (item_r.operation == OP_FREE && !d_served) ? item_r.handle : 32'd0;
    end
    if (cmd.finish && use_ram_r) res_r <= ram_rdata;
  end

  pmoc_ram #(.WIDTH(32), .DEPTH(HD)) u_store (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(item_r.handle),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign out_item.served = served_r;
  assign out_item.handle_res = res_r;
  assign out_item.source = src_r;
endmodule
`default_nettype wire

[src/per_cpu_magazine_object_cache_top.sv]
// A free or a miss goes from the decide state straight to the result, and a served
// allocate passes through a read state first for the registered handle store read.
// Only one item is in flight: a new input is taken only once the controller is idle.
// Reset (rst_n low, synchronous) clears fill counts, depot depths and the
// controller, and reloads each CPU's magazines and the capacity register.
`default_nettype none
module per_cpu_magazine_object_cache_top import pmoc_pkg::*; #(
  parameter int NUM_CPUS = NUM_CPUS_DEF,
  parameter int MAX_CAPACITY = MAX_CAPACITY_DEF,
  parameter int POOL_MAGAZINES = POOL_MAGAZINES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_item_t       out_data,
  input  wire logic       cfg_we,
  input  wire logic [6:0] cfg_wdata
);
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  pmoc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  pmoc_dp #(.NUM_CPUS(NUM_CPUS), .MAX_CAPACITY(MAX_CAPACITY),
            .POOL_MAGAZINES(POOL_MAGAZINES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_item(in_data), .cmd(cmd), .sts(sts), .out_item(out_data)
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input accepted while result pending");
  a_served_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.served == (out_data.source != SRC_BACKING)))
    else $error("served and source disagree");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.decide, cmd.finish})) else $error("command overlap");
endmodule
`default_nettype wire

[bench/pmoc_checker.sv]
`default_nettype none
module pmoc_checker import pmoc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_stall,
  input  wire in_item_t   in_data,
  input  wire logic       out_valid,
  input  wire logic       out_stall,
  input  wire out_item_t  out_data,
  input  wire logic       cfg_we,
  input  wire logic [6:0] cfg_wdata,
  output int              fail_count,
  output int              pending,
  output int              result_count,
  output int              source_seen [4]
);
  localparam int NCPU = NUM_CPUS_DEF;
  localparam int MAXCAP = MAX_CAPACITY_DEF;
  localparam int POOL = POOL_MAGAZINES_DEF;

  // Mirror of the cache contents.
  logic [31:0] slot_mem [POOL*MAXCAP];
  int          mag_fill [POOL];
  int          cur_mag [NCPU];
  logic        cur_ok [NCPU];
  int          alt_mag [NCPU];
  logic        alt_ok [NCPU];
  int          full_mags [POOL];
  int          full_cnt;
  int          empty_mags [POOL];
  int          empty_cnt;
  int          pool_next;
  logic [6:0]  capacity;
  out_item_t   expected_q [$];

  function automatic void restart_cache();
    for (int m = 0; m < POOL; m++) mag_fill[m] = 0;
    for (int c = 0; c < NCPU; c++) begin
      cur_mag[c] = 2 * c;
      cur_ok[c] = (2 * c) < POOL;
      alt_mag[c] = 2 * c + 1;
      alt_ok[c] = (2 * c + 1) < POOL;
    end
    full_cnt = 0;
    empty_cnt = 0;
    pool_next = (2 * NCPU > POOL) ? POOL : 2 * NCPU;
    capacity = CAPACITY_RESET;
  endfunction

  function automatic void push_handle(int m, logic [31:0] h);
    if (mag_fill[m] < MAXCAP) begin
      slot_mem[m * MAXCAP + mag_fill[m]] = h;
      mag_fill[m]++;
    end
  endfunction

  function automatic logic [31:0] pop_handle(int m);
    if (mag_fill[m] == 0 || mag_fill[m] > MAXCAP) return '0;
    mag_fill[m]--;
    return slot_mem[m * MAXCAP + mag_fill[m]];
  endfunction

  function automatic out_item_t cache_access(in_item_t it);
    out_item_t r;
    int lim, c, lm, pm, nm;
    logic lv, pv, got;
    lim = (capacity == 0) ? 1 : (capacity > MAXCAP) ? MAXCAP : int'(capacity);
    c = (it.cpu >= NCPU) ? 0 : int'(it.cpu);
    lm = cur_mag[c];
    lv = cur_ok[c];
    pm = alt_mag[c];
    pv = alt_ok[c];
    r.served = 1'b0;
    r.handle_res = '0;
    r.source = SRC_BACKING;
    got = 1'b0;
    nm = 0;
    if (it.operation == OP_ALLOC) begin
      if (lv && mag_fill[lm] > 0) begin
        r.handle_res = pop_handle(lm);
        r.served = 1'b1;
        r.source = SRC_LOADED;
      end else if (pv && mag_fill[pm] > 0) begin
        cur_mag[c] = pm; cur_ok[c] = 1'b1;
        alt_mag[c] = lm; alt_ok[c] = lv;
        r.handle_res = pop_handle(pm);
        r.served = 1'b1;
        r.source = SRC_PREVIOUS;
      end else if (full_cnt > 0) begin
        full_cnt--;
        nm = full_mags[full_cnt];
        // An empty loaded magazine is parked before the full one comes in.
        if (lv && mag_fill[lm] == 0 && empty_cnt < POOL) begin
          empty_mags[empty_cnt] = lm;
          empty_cnt++;
        end
        cur_mag[c] = nm; cur_ok[c] = 1'b1;
        r.handle_res = pop_handle(nm);
        r.served = 1'b1;
        r.source = SRC_DEPOT;
      end
    end else begin
      if (lv && mag_fill[lm] < lim) begin
        push_handle(lm, it.handle);
        r.served = 1'b1;
        r.source = SRC_LOADED;
      end else if (pv && mag_fill[pm] < lim) begin
        cur_mag[c] = pm; cur_ok[c] = 1'b1;
        alt_mag[c] = lm; alt_ok[c] = lv;
        push_handle(pm, it.handle);
        r.served = 1'b1;
        r.source = SRC_PREVIOUS;
      end else if (lv) begin
        if (full_cnt < POOL) begin
          full_mags[full_cnt] = lm;
          full_cnt++;
        end
        if (empty_cnt > 0) begin
          empty_cnt--;
          nm = empty_mags[empty_cnt];
          got = 1'b1;
        end else if (pool_next < POOL) begin
          nm = pool_next;
          pool_next++;
          mag_fill[nm] = 0;
          got = 1'b1;
        end
        if (got) begin
          cur_mag[c] = nm; cur_ok[c] = 1'b1;
          push_handle(nm, it.handle);
          r.served = 1'b1;
          r.source = SRC_DEPOT;
        end else begin
          cur_ok[c] = 1'b0;
        end
      end
      if (!r.served) r.handle_res = it.handle;
    end
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
    result_count = 0;
    for (int s = 0; s < 4; s++) source_seen[s] = 0;
    restart_cache();
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      restart_cache();
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        result_count++;
        if (expected_q.size() == 0) begin
          $error("result transfer with nothing expected: %p", out_data);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          source_seen[out_data.source]++;
          if (out_data.served !== want.served) begin
            $error("served: expected %0d, got %0d", want.served, out_data.served);
            fail_count++;
          end
          if (out_data.handle_res !== want.handle_res) begin
            $error("handle_res: expected %h, got %h", want.handle_res, out_data.handle_res);
            fail_count++;
          end
          if (out_data.source !== want.source) begin
            $error("source: expected %0d, got %0d", want.source, out_data.source);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) expected_q.push_back(cache_access(in_data));
      if (cfg_we) capacity = cfg_wdata;
    end
    pending = expected_q.size();
  end
endmodule
`default_nettype wire

[bench/tb.sv]
`default_nettype none
module tb;
  import pmoc_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic       cfg_we = 1'b0;
  logic [6:0] cfg_wdata = '0;

  int fail_count, pending, result_count;
  int source_seen [4];
  int idle_pct = 0;
  int stall_pct = 0;
  int sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  per_cpu_magazine_object_cache_top uut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data, .cfg_we, .cfg_wdata
  );

  pmoc_checker chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_we, .cfg_wdata, .fail_count, .pending, .result_count,
    .source_seen
  );

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  task automatic issue(logic op, logic [5:0] cpu, logic [31:0] h);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= '{operation: op, cpu: cpu, handle: h};
    @(posedge clk iff !in_stall);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    // The controller returns to idle at the edge on which the result leaves.
    repeat (8) @(posedge clk);
  endtask

  task automatic set_capacity(logic [6:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    static logic [6:0] caps [8] = '{7'd1, 7'd2, 7'd127, 7'd0, 7'd5, 7'd3, 7'd100, 7'd64};
    logic       op;
    logic [5:0] cpu;
    int         run;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: misses on an empty cache, then fill and drain at the extremes.
    issue(OP_ALLOC, 6'd0, 32'h0);
    issue(OP_ALLOC, 6'd63, 32'hFFFF_FFFF);
    issue(OP_FREE, 6'd63, 32'hFFFF_FFFF);
    issue(OP_FREE, 6'd0, 32'h0000_0000);
    issue(OP_ALLOC, 6'd4, 32'h1234_5678);
    issue(OP_ALLOC, 6'd0, 32'h0);
    set_capacity(7'd1);
    // Capacity one: swap, depot parking, pool exhaustion and the free miss.
    for (int i = 0; i < 12; i++) issue(OP_FREE, 6'd2, 32'hA5A5_0000 + i);
    for (int i = 0; i < 5; i++) issue(OP_ALLOC, 6'd1, 32'h0);
    issue(OP_FREE, 6'd3, 32'h5A5A_5A5A);

    for (int ph = 0; ph < 8; ph++) begin
      set_capacity(caps[ph]);
      case (ph % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 78; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 78; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      for (int n = 0; n < 90; ) begin
        // Runs of one operation on one CPU fill and empty magazines.
        op = $urandom_range(1);
        cpu = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(3));
        run = $urandom_range(1, 20);
        for (int k = 0; k < run; k++, n++) begin
          if ($urandom_range(9) == 0) issue(1'($urandom), 6'($urandom), $urandom);
          else issue(op, cpu, $urandom);
        end
        if (ph == 3 && n > 40 && n <= 40 + run) drain();
      end
    end

    idle_pct = 0;
    drain();
    repeat (20) @(posedge clk);
    $display("Covered %0d requests and %0d results over capacities 0 to 127.",
             sent, result_count);
    $display("Sources seen: loaded %0d, previous %0d, depot %0d, backing %0d.",
             source_seen[0], source_seen[1], source_seen[2], source_seen[3]);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("== FAIL ==");
    $finish;
  end
endmodule
`default_nettype wire

[filelist.f]
src/pmoc_pkg.sv
src/pmoc_ram.sv
src/pmoc_ctrl.sv
src/pmoc_dp.sv
src/per_cpu_magazine_object_cache_top.sv
bench/pmoc_checker.sv
bench/tb.sv
